[sv/hcpt_pkg.sv]
package hcpt_pkg;

   // Table geometry
   localparam int ENTRIES_DEF = 16;
   localparam int ID_W        = 4;
   localparam int CTX_W       = 8;
   localparam int ADDR_W      = 64;
   localparam int LEN_W       = 8;
   localparam int LIFE_W      = 16;
   localparam int MIN_W       = 32;
   localparam int MODE_W      = 2;
   localparam int MAX_LEN     = 128;

   // Stream packing
   localparam int REQ_DATA_W  = 168;
   localparam int RSP_DATA_W  = 160;

   // Leading-zero count is split into 16-bit chunks
   localparam int CHUNK_W     = 16;
   localparam int CHUNKS      = MAX_LEN / CHUNK_W;
   localparam int LZ_W        = 4;

   typedef enum logic [1:0] {
      MODE_ADDR   = 2'd0,
      MODE_ID     = 2'd1,
      MODE_UPDATE = 2'd2,
      MODE_TICK   = 2'd3
   } mode_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DRAIN,
      ST_REFRESH,
      ST_UPDATE,
      ST_FINISH
   } state_type;

   // Leading zeros of a nonzero chunk; the result for zero is not used.
   function automatic logic [LZ_W-1:0] lzc16(input logic [CHUNK_W-1:0] x);
      logic [LZ_W-1:0] n;
      n = '0;
      for (int i = 0; i < CHUNK_W; i++) begin
         if (x[i]) begin
            n = LZ_W'(CHUNK_W - 1 - i);
         end
      end
      return n;
   endfunction

endpackage

[sv/header_context_prefix_table.sv]
// Table of header-compression contexts, each with a 128-bit prefix (stored
// masked to its length), a prefix length, a compress flag, a remaining
// lifetime in minutes and an absolute expiry minute. The request's tuser
// selects the operation: address lookup (the matching entry with the most
// bits in common with the address wins, lowest id on a tie), id lookup, entry
// update, or minute tick. Lookups refresh the lifetime of every entry they
// touch; an expired entry loses its compress flag. One request is worked on
// at a time and req_tready is high only while the block is idle. An address
// lookup walks the table through one shared refresh and prefix-compare unit,
// one entry per cycle, then drains a two-stage compare pipeline. An id
// lookup passes a refresh state and an update an update state; a tick, an
// id lookup beyond the table and a rejected update go straight to the
// finish state. Every request produces exactly one response; the response
// sits in an output register, so the block finishes its own work while the
// response waits, and only the load of a new response waits on rsp_tready.
// On a miss (rsp_tuser low) all response data fields are zero. Reset empties
// the table and clears the minute counter; no clearing pass is needed.
module header_context_prefix_table #(
   parameter int ENTRIES = hcpt_pkg::ENTRIES_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // addr_upper[63:0], addr_lower[127:64], ctx_id[135:128],
   // new_length[143:136], new_lifetime[159:144], compress[160], zero pad
   input  logic [hcpt_pkg::REQ_DATA_W-1:0]   req_tdata,
   // mode[1:0]
   input  logic [hcpt_pkg::MODE_W-1:0]       req_tuser,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // found_id[3:0], found_compress[4], found_length[12:5],
   // found_lifetime[28:13], prefix_upper[92:29], prefix_lower[156:93], zero pad
   output logic [hcpt_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   // hit[0]
   output logic [0:0]                        rsp_tuser
);

   import hcpt_pkg::*;

   localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam logic [IW-1:0]    LAST_IDX   = IW'(ENTRIES - 1);
   localparam logic [CTX_W-1:0] ENTRIES_ID = CTX_W'(ENTRIES);
   localparam logic [LEN_W-1:0] LEN_FULL   = LEN_W'(MAX_LEN);

   // Request fields
   mode_type             req_mode;
   logic [ADDR_W-1:0]    req_addr_upper;
   logic [ADDR_W-1:0]    req_addr_lower;
   logic [CTX_W-1:0]     req_ctx_id;
   logic [LEN_W-1:0]     req_len_bits;
   logic [LIFE_W-1:0]    req_lifetime;
   logic                 req_compress;
   logic                 req_accept;
   logic                 req_id_ok;

   assign req_mode       = mode_type'(req_tuser);
   assign req_addr_upper = req_tdata[63:0];
   assign req_addr_lower = req_tdata[127:64];
   assign req_ctx_id     = req_tdata[135:128];
   assign req_len_bits   = req_tdata[143:136];
   assign req_lifetime   = req_tdata[159:144];
   assign req_compress   = req_tdata[160];
   assign req_accept     = req_tvalid && req_tready;
   assign req_id_ok      = (req_ctx_id < ENTRIES_ID);

   // Control and held request
   state_type            state_ff, state_in;
   mode_type             mode_ff;
   logic [ADDR_W-1:0]    addr_up_ff, addr_lo_ff;
   logic [LEN_W-1:0]     plen_ff;
   logic [LIFE_W-1:0]    life_ff;
   logic                 comp_ff;
   logic                 ok_ff;
   logic [IW-1:0]        idx_ff, win_ff;
   logic [LEN_W-1:0]     best_ff;
   logic                 found_ff;
   logic [MIN_W-1:0]     minute_ff;

   // Compare pipeline stage
   logic                              s1_valid_ff;
   logic [IW-1:0]                     s1_idx_ff;
   logic [LEN_W-1:0]                  s1_len_ff;
   logic [CHUNKS-1:0]                 s1_nz_ff;
   logic [CHUNKS-1:0][LZ_W-1:0]       s1_lz_ff;

   // Response register
   logic                         rsp_valid_ff;
   logic                         rsp_hit_ff;
   logic [RSP_DATA_W-1:0]        rsp_data_ff;
   logic                         rsp_load;
   logic                         rsp_hit_in;
   logic [RSP_DATA_W-1:0]        rsp_data_in;

   // Context table
   logic [ADDR_W-1:0]    ent_up_ff   [ENTRIES];
   logic [ADDR_W-1:0]    ent_lo_ff   [ENTRIES];
   logic [LEN_W-1:0]     ent_len_ff  [ENTRIES];
   logic                 ent_comp_ff [ENTRIES];
   logic [LIFE_W-1:0]    ent_life_ff [ENTRIES];
   logic [MIN_W-1:0]     ent_exp_ff  [ENTRIES];

   // Single read port
   logic [IW-1:0]        rd_idx;
   logic [ADDR_W-1:0]    rd_up, rd_lo;
   logic [LEN_W-1:0]     rd_len;
   logic                 rd_comp;
   logic [LIFE_W-1:0]    rd_life;
   logic [MIN_W-1:0]     rd_exp;

   assign rd_idx  = (state_ff == ST_FINISH && mode_ff == MODE_ADDR) ? win_ff : idx_ff;
   assign rd_up   = ent_up_ff[rd_idx];
   assign rd_lo   = ent_lo_ff[rd_idx];
   assign rd_len  = ent_len_ff[rd_idx];
   assign rd_comp = ent_comp_ff[rd_idx];
   assign rd_life = ent_life_ff[rd_idx];
   assign rd_exp  = ent_exp_ff[rd_idx];

   // Shared lifetime refresh unit: one subtract and compare
   logic [MIN_W-1:0]     exp_left;
   logic                 expired;
   logic                 live;
   logic [LIFE_W-1:0]    rf_life;
   logic                 rf_comp;
   logic                 refresh_en;

   assign exp_left   = rd_exp - minute_ff;
   assign expired    = (minute_ff >= rd_exp);
   assign live       = (rd_life != '0) && !expired;
   assign rf_life    = live ? exp_left[LIFE_W-1:0] : '0;
   assign rf_comp    = live && rd_comp;
   assign refresh_en = (state_ff == ST_SCAN) || (state_ff == ST_REFRESH);

   // Shared prefix compare: per-chunk leading zeros of prefix ^ address
   logic [MAX_LEN-1:0]               diff;
   logic [CHUNKS-1:0]                chunk_nz;
   logic [CHUNKS-1:0][LZ_W-1:0]      chunk_lz;

   assign diff = {rd_up ^ addr_up_ff, rd_lo ^ addr_lo_ff};

   always_comb begin
      for (int c = 0; c < CHUNKS; c++) begin
         chunk_nz[c] = |diff[MAX_LEN - 1 - c * CHUNK_W -: CHUNK_W];
         chunk_lz[c] = lzc16(diff[MAX_LEN - 1 - c * CHUNK_W -: CHUNK_W]);
      end
   end

   // Second stage: combine chunks into the match length and pick the winner
   logic [LEN_W-1:0]     match_len;
   logic                 take;

   always_comb begin
      match_len = LEN_FULL;
      for (int c = CHUNKS - 1; c >= 0; c--) begin
         if (s1_nz_ff[c]) begin
            match_len = LEN_W'(c * CHUNK_W) + LEN_W'(s1_lz_ff[c]);
         end
      end
   end

   assign take = s1_valid_ff && (s1_len_ff != '0) && (s1_len_ff <= match_len)
                 && (match_len > best_ff);

   // Update path: saturate the length and build the prefix mask
   logic [LEN_W-1:0]     sat_len;
   logic [MAX_LEN-1:0]   upd_mask;
   logic                 upd_comp;
   logic [MIN_W-1:0]     upd_exp;

   assign sat_len  = (plen_ff > LEN_FULL) ? LEN_FULL : plen_ff;
   assign upd_comp = comp_ff && (life_ff != '0);
   assign upd_exp  = minute_ff + MIN_W'(life_ff);

   always_comb begin
      for (int i = 0; i < MAX_LEN; i++) begin
         upd_mask[i] = (LEN_W'(MAX_LEN - 1 - i) < sat_len);
      end
   end

   // Sequencer: next state and response formation
   always_comb begin
      state_in    = state_ff;
      rsp_load    = 1'b0;
      rsp_hit_in  = 1'b0;
      rsp_data_in = '0;
      req_tready  = (state_ff == ST_IDLE);

      case (mode_ff)
         MODE_ADDR:   rsp_hit_in = found_ff;
         MODE_ID:     rsp_hit_in = ok_ff && (rd_len != '0);
         MODE_UPDATE: rsp_hit_in = ok_ff;
         default:     rsp_hit_in = 1'b0;
      endcase
      if (rsp_hit_in) begin
         rsp_data_in = {3'b000, rd_lo, rd_up, rd_life, rd_len, rd_comp, ID_W'(rd_idx)};
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               case (req_mode)
                  MODE_ADDR:   state_in = ST_SCAN;
                  MODE_ID:     state_in = req_id_ok ? ST_REFRESH : ST_FINISH;
                  MODE_UPDATE: state_in = (req_id_ok && req_len_bits != '0) ?
                                          ST_UPDATE : ST_FINISH;
                  default:     state_in = ST_FINISH;
               endcase
            end
         end
         ST_SCAN: begin
            if (idx_ff == LAST_IDX) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN:   state_in = ST_FINISH;
         ST_REFRESH: state_in = ST_FINISH;
         ST_UPDATE:  state_in = ST_FINISH;
         ST_FINISH: begin
            // hold until the response register is free
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         minute_ff    <= '0;
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         found_ff     <= 1'b0;
      end else begin
         state_ff    <= state_in;
         s1_valid_ff <= (state_ff == ST_SCAN);
         if (req_accept && req_mode == MODE_TICK) begin
            minute_ff <= minute_ff + 1'b1;
         end
         if (req_accept) begin
            found_ff <= 1'b0;
         end else if (take) begin
            found_ff <= 1'b1;
         end
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Datapath registers
   always_ff @(posedge clock) begin
      if (req_accept) begin
         mode_ff    <= req_mode;
         addr_up_ff <= req_addr_upper;
         addr_lo_ff <= req_addr_lower;
         plen_ff    <= req_len_bits;
         life_ff    <= req_lifetime;
         comp_ff    <= req_compress;
         ok_ff      <= req_id_ok && (req_mode != MODE_UPDATE || req_len_bits != '0);
         idx_ff     <= (req_mode == MODE_ADDR) ? '0 : req_ctx_id[IW-1:0];
         best_ff    <= '0;
         win_ff     <= '0;
      end else begin
         if (state_ff == ST_SCAN) begin
            idx_ff <= idx_ff + 1'b1;
         end
         if (take) begin
            best_ff <= match_len;
            win_ff  <= s1_idx_ff;
         end
      end
      s1_idx_ff <= idx_ff;
      s1_len_ff <= rd_len;
      s1_nz_ff  <= chunk_nz;
      s1_lz_ff  <= chunk_lz;
      if (rsp_load) begin
         rsp_hit_ff  <= rsp_hit_in;
         rsp_data_ff <= rsp_data_in;
      end
   end

   // Table fields that reset clears
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int e = 0; e < ENTRIES; e++) begin
            ent_len_ff[e]  <= '0;
            ent_comp_ff[e] <= 1'b0;
            ent_life_ff[e] <= '0;
         end
      end else if (refresh_en) begin
         ent_life_ff[idx_ff] <= rf_life;
         ent_comp_ff[idx_ff] <= rf_comp;
      end else if (state_ff == ST_UPDATE) begin
         ent_len_ff[idx_ff]  <= sat_len;
         ent_comp_ff[idx_ff] <= upd_comp;
         ent_life_ff[idx_ff] <= life_ff;
      end
   end

   // Table fields read only after an update has written them
   always_ff @(posedge clock) begin
      if (state_ff == ST_UPDATE) begin
         ent_up_ff[idx_ff]  <= addr_up_ff & upd_mask[MAX_LEN-1:ADDR_W];
         ent_lo_ff[idx_ff]  <= addr_lo_ff & upd_mask[ADDR_W-1:0];
         ent_exp_ff[idx_ff] <= upd_exp;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_hit_ff;

`ifndef NO_ASSERTIONS
   // a miss carries all-zero data
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_hit_ff |-> rsp_data_ff == '0)
      else $error("miss response with nonzero data");

   // a compressible context always has lifetime left
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_hit_ff && rsp_data_ff[4] |-> rsp_data_ff[28:13] != '0)
      else $error("compress flag set with zero lifetime");

   // the compare stage only carries scanned entries
   assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff |-> $past(state_ff == ST_SCAN))
      else $error("compare stage loaded outside scan");

   // a tick advances the minute counter by one
   assert property (@(posedge clock) disable iff (reset)
      req_accept && req_mode == MODE_TICK |=> minute_ff == $past(minute_ff) + 1'b1)
      else $error("minute counter did not advance");

   // a hit never reports a length beyond the full prefix
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_hit_ff |-> rsp_data_ff[12:5] <= LEN_FULL
                                     && rsp_data_ff[12:5] != '0)
      else $error("reported prefix length out of range");
`endif

endmodule

[tb/testbench.sv]
`timescale 1ns / 100ps

// Check the context table from its two stream ports. A predictor keeps its own
// copy of the sixteen contexts and the minute counter. Every accepted request
// advances it and leaves one expected response in a queue, which the response
// monitor compares field by field, in order.
module testbench;
   import hcpt_pkg::*;

   localparam int ENTRIES      = ENTRIES_DEF;
   localparam int RANDOM_ITEMS = 800;
   localparam int CYCLE_LIMIT  = 200000;

   // One request as the sender sees it; packed into req_tdata/req_tuser on drive.
   typedef struct packed {
      mode_type          mode;
      logic [ADDR_W-1:0] upper;
      logic [ADDR_W-1:0] lower;
      logic [CTX_W-1:0]  ctx_id;
      logic [LEN_W-1:0]  plen;
      logic [LIFE_W-1:0] life;
      logic              comp;
   } ctx_request_type;

   // One response, unpacked from rsp_tdata/rsp_tuser.
   typedef struct packed {
      logic              hit;
      logic [ID_W-1:0]   ctx;
      logic              compress;
      logic [LEN_W-1:0]  ctx_len;
      logic [LIFE_W-1:0] lifetime;
      logic [ADDR_W-1:0] upper;
      logic [ADDR_W-1:0] lower;
   } ctx_result_type;

   // Directed row: a request and, where it is obvious, the response typed in.
   typedef struct {
      ctx_request_type req;
      bit              typed;
      ctx_result_type  want;
   } stim_row_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic [MODE_W-1:0]     req_tuser = MODE_TICK;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic [0:0]            rsp_tuser;

   // Predictor state: the table as the block should hold it.
   logic [ADDR_W-1:0] tbl_hi     [ENTRIES] = '{default: '0};
   logic [ADDR_W-1:0] tbl_lo     [ENTRIES] = '{default: '0};
   logic [LEN_W-1:0]  tbl_len    [ENTRIES] = '{default: '0};
   logic              tbl_comp   [ENTRIES] = '{default: '0};
   logic [LIFE_W-1:0] tbl_life   [ENTRIES] = '{default: '0};
   logic [MIN_W-1:0]  tbl_expiry [ENTRIES] = '{default: '0};
   logic [MIN_W-1:0]  minute_now = '0;

   ctx_result_type awaited_results[$];
   int             fault_count = 0;
   int             cycle_count = 0;
   int             rsp_taken = 0;

   header_context_prefix_table #(.ENTRIES(ENTRIES)) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // ---------------------------------------------------------------- predictor

   // Refresh one context's lifetime against the minute counter; an expired or
   // lifetime-less context loses its compress flag.
   function automatic void age_entry(int idx);
      if (tbl_life[idx] == '0) begin
         tbl_comp[idx] = 1'b0;
      end else if (minute_now >= tbl_expiry[idx]) begin
         tbl_life[idx] = '0;
         tbl_comp[idx] = 1'b0;
      end else begin
         tbl_life[idx] = LIFE_W'(tbl_expiry[idx] - minute_now);
      end
   endfunction

   // Count the leading bits in which the stored prefix equals the address.
   function automatic int common_bits(int idx, logic [ADDR_W-1:0] hi,
                                      logic [ADDR_W-1:0] lo);
      logic [2*ADDR_W-1:0] diff;
      int                  n;
      diff = {tbl_hi[idx], tbl_lo[idx]} ^ {hi, lo};
      n = 0;
      while (n < MAX_LEN && !diff[MAX_LEN-1-n]) n++;
      return n;
   endfunction

   function automatic ctx_result_type entry_view(int idx);
      ctx_result_type v;
      v.hit      = 1'b1;
      v.ctx      = ID_W'(idx);
      v.compress = tbl_comp[idx];
      v.ctx_len  = tbl_len[idx];
      v.lifetime = tbl_life[idx];
      v.upper    = tbl_hi[idx];
      v.lower    = tbl_lo[idx];
      return v;
   endfunction

   // Apply one request to the predicted table and return the response it owes.
   function automatic ctx_result_type predict_context(ctx_request_type r);
      ctx_result_type      res;
      int                  best;
      int                  win;
      int                  m;
      int                  p;
      int                  idx;
      logic [2*ADDR_W-1:0] mask;
      res = '0;
      idx = int'(r.ctx_id);
      case (r.mode)
         MODE_ADDR: begin
            // longest match wins; strict compare keeps the lowest id on a tie
            best = 0;
            win  = -1;
            for (int k = 0; k < ENTRIES; k++) begin
               age_entry(k);
               if (tbl_len[k] != '0) begin
                  m = common_bits(k, r.upper, r.lower);
                  if (int'(tbl_len[k]) <= m && m > best) begin
                     best = m;
                     win  = k;
                  end
               end
            end
            if (win >= 0) res = entry_view(win);
         end
         MODE_ID: begin
            if (idx < ENTRIES) begin
               age_entry(idx);
               if (tbl_len[idx] != '0) res = entry_view(idx);
            end
         end
         MODE_UPDATE: begin
            if (idx < ENTRIES && r.plen != '0) begin
               p    = (int'(r.plen) > MAX_LEN) ? MAX_LEN : int'(r.plen);
               mask = {(2*ADDR_W){1'b1}} << (MAX_LEN - p);
               tbl_life[idx]   = r.life;
               tbl_len[idx]    = LEN_W'(p);
               tbl_comp[idx]   = (r.life == '0) ? 1'b0 : r.comp;
               {tbl_hi[idx], tbl_lo[idx]} = {r.upper, r.lower} & mask;
               tbl_expiry[idx] = MIN_W'(r.life) + minute_now;
               res = entry_view(idx);
            end
         end
         default: begin
            minute_now = minute_now + 1'b1;
         end
      endcase
      return res;
   endfunction

   // ---------------------------------------------------------------- stimulus

   function automatic stim_row_type stim(mode_type mode, logic [ADDR_W-1:0] hi,
                                         logic [ADDR_W-1:0] lo, logic [CTX_W-1:0] id,
                                         logic [LEN_W-1:0] plen, logic [LIFE_W-1:0] life,
                                         logic comp);
      stim_row_type s;
      s.req   = '{mode, hi, lo, id, plen, life, comp};
      s.typed = 1'b0;
      s.want  = '0;
      return s;
   endfunction

   function automatic stim_row_type with_result(stim_row_type s, ctx_result_type want);
      s.typed = 1'b1;
      s.want  = want;
      return s;
   endfunction

   function automatic ctx_result_type hit_of(int id, logic comp, int len, int life,
                                             logic [ADDR_W-1:0] hi, logic [ADDR_W-1:0] lo);
      return '{1'b1, ID_W'(id), comp, LEN_W'(len), LIFE_W'(life), hi, lo};
   endfunction

   // Draw a random request. Most address lookups aim at a stored prefix with
   // noise below a random cut, so that matches, near misses and ties occur.
   function automatic ctx_request_type draw_request();
      ctx_request_type     r;
      int                  pick;
      int                  j;
      int                  cut;
      logic [2*ADDR_W-1:0] noise;
      r.mode   = MODE_TICK;
      r.upper  = {$urandom, $urandom};
      r.lower  = {$urandom, $urandom};
      r.ctx_id = CTX_W'($urandom_range(0, ENTRIES - 1));
      r.plen   = LEN_W'($urandom);
      r.life   = LIFE_W'($urandom);
      r.comp   = 1'($urandom);
      if ($urandom_range(0, 9) == 0) r.ctx_id = CTX_W'($urandom);
      j     = $urandom_range(0, ENTRIES - 1);
      cut   = $urandom_range(0, MAX_LEN);
      noise = {$urandom, $urandom, $urandom, $urandom} & ({(2*ADDR_W){1'b1}} >> (MAX_LEN - cut));
      pick  = $urandom_range(0, 99);
      if (pick < 30) begin
         r.mode = MODE_UPDATE;
         case ($urandom_range(0, 5))
            0: r.plen = LEN_W'($urandom_range(0, 16));
            1: r.plen = LEN_W'($urandom_range(48, 80));
            2: r.plen = LEN_W'($urandom_range(112, MAX_LEN));
            3: r.plen = LEN_W'($urandom_range(MAX_LEN + 1, 255));
            default: r.plen = LEN_W'($urandom_range(1, 255));
         endcase
         // short lifetimes so that ticks expire them during the run
         case ($urandom_range(0, 4))
            0: r.life = '0;
            1: r.life = '1;
            2: r.life = LIFE_W'($urandom);
            default: r.life = LIFE_W'($urandom_range(1, 8));
         endcase
         // clone a neighbor's prefix now and then to build ties
         if ($urandom_range(0, 3) == 0) {r.upper, r.lower} = {tbl_hi[j], tbl_lo[j]} ^ noise;
      end else if (pick < 65) begin
         r.mode = MODE_ADDR;
         if ($urandom_range(0, 3) != 0) {r.upper, r.lower} = {tbl_hi[j], tbl_lo[j]} ^ noise;
      end else if (pick < 88) begin
         r.mode = MODE_ID;
      end
      return r;
   endfunction

   // Drive one request, hold it until accepted, then queue its response.
   // Lower tvalid only when a gap follows, so it never drops and rises in one step.
   task automatic send_request(input ctx_request_type r, input ctx_result_type want,
                               input bit calm);
      int gap;
      gap = calm ? 0 : $urandom_range(0, 4);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= r.mode;
      req_tdata  <= {7'd0, r.comp, r.life, r.plen, r.ctx_id, r.lower, r.upper};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      awaited_results.push_back(want);
   endtask

   initial begin : stimulus
      stim_row_type    directed[$];
      ctx_request_type r;
      ctx_result_type  want;

      // Reject paths on an empty table, then the update extremes.
      directed.push_back(with_result(stim(MODE_ADDR, '1, '1, 8'd0, 8'd0, 16'd0, 1'b0), '0));
      directed.push_back(with_result(stim(MODE_ID, '0, '0, 8'd0, 8'd0, 16'd0, 1'b0), '0));
      directed.push_back(with_result(stim(MODE_ID, '1, '1, 8'hFF, 8'hFF, '1, 1'b1), '0));
      directed.push_back(with_result(stim(MODE_UPDATE, '1, '1, 8'd16, 8'd8, 16'd5, 1'b1), '0));
      directed.push_back(with_result(stim(MODE_UPDATE, '1, '1, 8'd0, 8'd0, 16'd5, 1'b1), '0));
      // length above 128 saturates; full prefix kept
      directed.push_back(with_result(stim(MODE_UPDATE, '1, '1, 8'd0, 8'hFF, '1, 1'b1),
                                     hit_of(0, 1'b1, MAX_LEN, 16'hFFFF, '1, '1)));
      // zero lifetime forces compress off; one-bit prefix masks the rest away
      directed.push_back(with_result(stim(MODE_UPDATE, 64'h7FFF_FFFF_FFFF_FFFF, '1,
                                          8'd15, 8'd1, 16'd0, 1'b1),
                                     hit_of(15, 1'b0, 1, 0, '0, '0)));
      directed.push_back(stim(MODE_UPDATE, 64'hFE80_0000_0000_0000, 64'h0123_4567_89AB_CDEF,
                              8'd1, 8'd64, 16'd3, 1'b1));
      directed.push_back(stim(MODE_UPDATE, 64'hFE80_0000_0000_0000, 64'h0123_4567_89AB_CDEF,
                              8'd2, 8'd65, 16'd100, 1'b1));
      // ids 3 and 4 hold the same prefix: the lower id must win
      directed.push_back(stim(MODE_UPDATE, 64'hFE80_0000_0000_0000, 64'h0123_4567_89AB_CDEE,
                              8'd3, 8'd127, 16'd2, 1'b1));
      directed.push_back(stim(MODE_UPDATE, 64'hFE80_0000_0000_0000, 64'h0123_4567_89AB_CDEE,
                              8'd4, 8'd127, 16'd50, 1'b0));
      directed.push_back(stim(MODE_ADDR, 64'hFE80_0000_0000_0000, 64'h0123_4567_89AB_CDEF,
                              8'd0, 8'd0, 16'd0, 1'b0));
      directed.push_back(stim(MODE_ADDR, '1, '1, 8'd0, 8'd0, 16'd0, 1'b0));
      directed.push_back(stim(MODE_ADDR, '0, '0, 8'd0, 8'd0, 16'd0, 1'b0));
      directed.push_back(stim(MODE_ADDR, 64'h8000_0000_0000_0000, '0, 8'd0, 8'd0, 16'd0, 1'b0));
      // advance three minutes: ids 1 and 3 expire
      repeat (3) directed.push_back(with_result(stim(MODE_TICK, '0, '0, 8'd0, 8'd0, 16'd0,
                                                     1'b0), '0));
      directed.push_back(stim(MODE_ID, '0, '0, 8'd1, 8'd0, 16'd0, 1'b0));
      directed.push_back(stim(MODE_ID, '0, '0, 8'd3, 8'd0, 16'd0, 1'b0));
      directed.push_back(stim(MODE_ID, '0, '0, 8'd15, 8'd0, 16'd0, 1'b0));
      // an expired entry stays valid and still wins the tie
      directed.push_back(stim(MODE_ADDR, 64'hFE80_0000_0000_0000, 64'h0123_4567_89AB_CDEF,
                              8'd0, 8'd0, 16'd0, 1'b0));
      directed.push_back(stim(MODE_ID, '0, '0, 8'd4, 8'd0, 16'd0, 1'b0));
      directed.push_back(with_result(stim(MODE_TICK, '1, '1, 8'hFF, 8'hFF, '1, 1'b1), '0));

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Walk the table; the predictor advances on every row even when the
      // response is typed in, so that its state stays in step.
      foreach (directed[i]) begin
         want = predict_context(directed[i].req);
         if (directed[i].typed) want = directed[i].want;
         send_request(directed[i].req, want, 1'b0);
      end

      for (int k = 0; k < RANDOM_ITEMS; k++) begin
         // halfway: hold the sender until every response is back
         if (k == RANDOM_ITEMS / 2) begin
            req_tvalid <= 1'b0;
            while (awaited_results.size() != 0) @(posedge clock);
         end
         r    = draw_request();
         want = predict_context(r);
         // every fourth stretch of 48 requests runs back to back
         send_request(r, want, ((k / 48) % 4) == 3);
      end
      req_tvalid <= 1'b0;

      // Drain, then let a full table scan pass to catch stray responses.
      while (awaited_results.size() != 0) @(posedge clock);
      repeat (ENTRIES + 24) @(posedge clock);
      if (fault_count == 0 && awaited_results.size() == 0) begin
         $display("PASS header_context_prefix_table");
      end else begin
         $display("FAIL header_context_prefix_table");
      end
      $finish;
   end

   // ---------------------------------------------------------------- response side

   // Stall the receiver at random before each response, with calm stretches.
   initial begin : receiver
      int stall;
      forever begin
         stall = (((rsp_taken / 40) % 3) == 1) ? 0 : $urandom_range(0, 4);
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         @(posedge clock);
         while (!rsp_tvalid) @(posedge clock);
         rsp_taken++;
      end
   end

   function automatic void note_fault(string msg);
      if (fault_count < 10) $display("%s", msg);
      fault_count++;
   endfunction

   // Compare each accepted response against the oldest expectation.
   always @(posedge clock) begin : monitor
      ctx_result_type got;
      ctx_result_type want;
      string          bad;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.hit      = rsp_tuser[0];
         got.ctx      = rsp_tdata[3:0];
         got.compress = rsp_tdata[4];
         got.ctx_len  = rsp_tdata[12:5];
         got.lifetime = rsp_tdata[28:13];
         got.upper    = rsp_tdata[92:29];
         got.lower    = rsp_tdata[156:93];
         if (awaited_results.size() == 0) begin
            note_fault($sformatf("response at cycle %0d with no request pending", cycle_count));
         end else begin
            want = awaited_results.pop_front();
            bad  = "";
            if (got.hit !== want.hit) bad = {bad, " hit"};
            if (got.ctx !== want.ctx) bad = {bad, " id"};
            if (got.compress !== want.compress) bad = {bad, " compress"};
            if (got.ctx_len !== want.ctx_len) bad = {bad, " length"};
            if (got.lifetime !== want.lifetime) bad = {bad, " lifetime"};
            if (got.upper !== want.upper) bad = {bad, " upper"};
            if (got.lower !== want.lower) bad = {bad, " lower"};
            if (bad != "") begin
               note_fault($sformatf({"mismatch at cycle %0d on%s\n",
                  "  want hit=%0b id=%0d comp=%0b len=%0d life=%0d prefix=%h_%h\n",
                  "  got  hit=%0b id=%0d comp=%0b len=%0d life=%0d prefix=%h_%h"},
                  cycle_count, bad,
                  want.hit, want.ctx, want.compress, want.ctx_len, want.lifetime,
                  want.upper, want.lower,
                  got.hit, got.ctx, got.compress, got.ctx_len, got.lifetime,
                  got.upper, got.lower));
            end
         end
      end
   end

   // Drop the run if it hangs.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("FAIL header_context_prefix_table");
         $finish;
      end
   end

endmodule

[files.f]
sv/hcpt_pkg.sv
sv/header_context_prefix_table.sv
tb/testbench.sv
